### rtl/tvpts_pkg.sv
package tvpts_pkg;

    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_TRIGGER = 2'd1;
    localparam logic [1:0] MODE_SILENCE = 2'd2;

    localparam int SEQ_COUNT   = 6;
    localparam int STATE_DEPTH = 1;
    localparam int STATE_AW    = 1;

    typedef struct packed {
        logic [3:0]  v1_prio;
        logic [3:0]  v2_prio;
        logic [4:0]  v1_next;
        logic [4:0]  v2_next;
        logic [1:0]  v1_ticks;
        logic [1:0]  v2_ticks;
        logic [15:0] v1_tone;
        logic [15:0] v2_tone;
    } state_t;

    localparam int STATE_W = $bits(state_t);

    localparam logic [15:0] ROM_HZ [32] = '{
        16'd250,  16'd0,
        16'd1000, 16'd2500, 16'd1000, 16'd2500, 16'd1000, 16'd2500, 16'd0,
        16'd7500, 16'd5000, 16'd7500, 16'd5000, 16'd7500, 16'd5000, 16'd0,
        16'd2000, 16'd0,
        16'd1000, 16'd900,  16'd800,  16'd700,  16'd0,
        16'd1000, 16'd1200, 16'd1400, 16'd1600, 16'd1000, 16'd1200, 16'd1400,
        16'd1600, 16'd0
    };

    localparam logic [1:0] ROM_TICKS [32] = '{
        2'd3, 2'd0,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd0,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd0,
        2'd1, 2'd0,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd0,
        2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd0
    };

    function automatic logic [4:0] seq_start(input logic [2:0] eff);
        logic [4:0] r;
        case (eff)
            3'd0:    r = 5'd0;
            3'd1:    r = 5'd2;
            3'd2:    r = 5'd9;
            3'd3:    r = 5'd16;
            3'd4:    r = 5'd18;
            3'd5:    r = 5'd23;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/tvpts_ram.sv
module tvpts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/two_voice_priority_tone_sequencer.sv
// An accepted transfer is registered in the input stage, then on the m_ outputs.
// Throughput: one item per cycle while m_ready is high; voice state is read from
// the state RAM at acceptance, written back as the item advances, with a bypass.
// Reset: synchronous, active low; clears the pipeline and output valids and marks
// the state RAM as unwritten, so it reads as silence. No clearing pass.
module two_voice_priority_tone_sequencer #(
    parameter int NUM_EFFECTS = 6,
    parameter int ROM_PAIRS   = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [3:0]  s_priority_req,
    input  logic [2:0]  s_effect,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_voice1_freq,
    output logic        m_voice1_on,
    output logic [15:0] m_voice2_freq,
    output logic        m_voice2_on
);

    function automatic tvpts_pkg::state_t issue_pair(input tvpts_pkg::state_t st,
                                                     input logic [3:0] prio,
                                                     input logic [4:0] idx);
        tvpts_pkg::state_t r;
        logic [15:0]       hz;
        logic [1:0]        len;
        r   = st;
        hz  = tvpts_pkg::ROM_HZ[idx];
        len = tvpts_pkg::ROM_TICKS[idx];
        if (int'(idx) < ROM_PAIRS && hz != 16'd0) begin
            if (prio > r.v1_prio) begin
                r.v1_prio  = prio;
                r.v1_next  = idx + 5'd1;
                r.v1_tone  = hz;
                r.v1_ticks = len;
            end else if (prio > r.v2_prio) begin
                r.v2_prio  = prio;
                r.v2_next  = idx + 5'd1;
                r.v2_tone  = hz;
                r.v2_ticks = len;
            end
        end
        return r;
    endfunction

    logic                          s1_valid_reg;
    logic [1:0]                    s1_mode_reg;
    logic [3:0]                    s1_prio_reg;
    logic [2:0]                    s1_effect_reg;
    logic                          fwd_sel_reg;
    logic                          rd_init_reg;
    logic                          state_init_reg;
    tvpts_pkg::state_t             fwd_state_reg;
    logic                          m_valid_reg;
    logic [15:0]                   v1_freq_reg;
    logic                          v1_on_reg;
    logic [15:0]                   v2_freq_reg;
    logic                          v2_on_reg;

    logic                          accept;
    logic                          s1_adv;
    logic [tvpts_pkg::STATE_W-1:0] ram_rdata;
    tvpts_pkg::state_t             cur_state;
    tvpts_pkg::state_t             state_next;
    tvpts_pkg::state_t             tick_state;
    logic [3:0]                    p;

    assign s1_adv  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_adv;
    assign accept  = s_valid && s_ready;

    tvpts_ram #(
        .WIDTH(tvpts_pkg::STATE_W),
        .DEPTH(tvpts_pkg::STATE_DEPTH)
    ) u_state_ram (
        .aclk (aclk),
        .we   (s1_adv),
        .waddr('0),
        .wdata(state_next),
        .re   (accept),
        .raddr('0),
        .rdata(ram_rdata)
    );

    always_comb begin
        if (fwd_sel_reg) begin
            cur_state = fwd_state_reg;
        end else if (rd_init_reg) begin
            cur_state = tvpts_pkg::state_t'(ram_rdata);
        end else begin
            cur_state = '0;
        end
    end

    always_comb begin
        tick_state = cur_state;
        p          = 4'd0;
        if (tick_state.v1_ticks != 2'd0) begin
            tick_state.v1_ticks = tick_state.v1_ticks - 2'd1;
        end
        if (tick_state.v2_ticks != 2'd0) begin
            tick_state.v2_ticks = tick_state.v2_ticks - 2'd1;
        end
        if (tick_state.v1_ticks == 2'd0 && tick_state.v1_prio != 4'd0) begin
            p                  = tick_state.v1_prio;
            tick_state.v1_prio = 4'd0;
            tick_state         = issue_pair(tick_state, p, tick_state.v1_next);
        end
        if (tick_state.v2_ticks == 2'd0 && tick_state.v2_prio != 4'd0) begin
            p                  = tick_state.v2_prio;
            tick_state.v2_prio = 4'd0;
            tick_state         = issue_pair(tick_state, p, tick_state.v2_next);
        end
    end

    always_comb begin
        unique case (s1_mode_reg)
            tvpts_pkg::MODE_TICK: begin
                state_next = tick_state;
            end
            tvpts_pkg::MODE_TRIGGER: begin
                if (int'(s1_effect_reg) < NUM_EFFECTS &&
                    int'(s1_effect_reg) < tvpts_pkg::SEQ_COUNT) begin
                    state_next = issue_pair(cur_state, s1_prio_reg,
                                            tvpts_pkg::seq_start(s1_effect_reg));
                end else begin
                    state_next = cur_state;
                end
            end
            tvpts_pkg::MODE_SILENCE: begin
                state_next = '0;
            end
            default: begin
                state_next = cur_state;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            fwd_sel_reg    <= 1'b0;
            rd_init_reg    <= 1'b0;
            state_init_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
                fwd_sel_reg  <= s1_adv;
                rd_init_reg  <= state_init_reg;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                state_init_reg <= 1'b1;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_mode_reg   <= s_mode;
            s1_prio_reg   <= s_priority_req;
            s1_effect_reg <= s_effect;
        end
        if (s1_adv) begin
            fwd_state_reg <= state_next;
            v1_on_reg     <= state_next.v1_ticks != 2'd0;
            v2_on_reg     <= state_next.v2_ticks != 2'd0;
            v1_freq_reg   <= (state_next.v1_ticks != 2'd0) ? state_next.v1_tone : 16'd0;
            v2_freq_reg   <= (state_next.v2_ticks != 2'd0) ? state_next.v2_tone : 16'd0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_voice1_freq = v1_freq_reg;
    assign m_voice1_on   = v1_on_reg;
    assign m_voice2_freq = v2_freq_reg;
    assign m_voice2_on   = v2_on_reg;

endmodule

### rtl/tvpts_checker.sv
module tvpts_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_voice1_freq,
    input logic        m_voice1_on,
    input logic [15:0] m_voice2_freq,
    input logic        m_voice2_on
);

    a_v1_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_voice1_on) |-> (m_voice1_freq == 16'd0))
        else $error("voice 1 off with nonzero frequency");

    a_v2_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_voice2_on) |-> (m_voice2_freq == 16'd0))
        else $error("voice 2 off with nonzero frequency");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_voice1_freq) &&
                                   $stable(m_voice2_freq)))
        else $error("stalled result transfer changed");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input held off without a stalled result");

endmodule

bind two_voice_priority_tone_sequencer tvpts_checker u_tvpts_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_voice1_freq(m_voice1_freq),
    .m_voice1_on  (m_voice1_on),
    .m_voice2_freq(m_voice2_freq),
    .m_voice2_on  (m_voice2_on)
);
